>>> rtl/core/mvt_pkg.sv
// Shared types, constants and helpers for the matrix-vector transform core.
package mvt_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed port widths of the vector and result fields
  localparam int PORT_WIDTH  = 32;
  localparam int LANES       = 4;
  localparam int CELLS       = 4;

  // Configuration register file: two 64-bit words per matrix row
  localparam int NUM_REGS    = 8;
  localparam int REG_WIDTH   = 64;
  localparam int HALF_WIDTH  = 32;
  localparam int CFG_INDEX_W = 4;
  localparam int REG_SEL_W   = $clog2(NUM_REGS);

  typedef struct packed {
    logic valid;
    logic is_column;
  } stage_ctrl_t;

  // Identity matrix at reset: 1.0 sits on the diagonal of each row pair
  function automatic logic [REG_WIDTH-1:0] reset_value(input int unsigned idx,
                                                       input int unsigned frac);
    logic [REG_WIDTH-1:0] v;
    int unsigned row;
    v   = '0;
    row = idx >> 1;
    if ((row >> 1) == (idx & 1))
      v = REG_WIDTH'(1) << (frac + HALF_WIDTH * (row & 1));
    return v;
  endfunction

endpackage

>>> rtl/core/mvt_cell.sv
// One multiply-accumulate cell: adds its element's four products to the running sums.
module mvt_cell #(
  parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
  parameter int LANE       = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mvt_pkg::stage_ctrl_t          ctrl_in,
  output logic                          in_free,
  input  logic signed [DATA_WIDTH-1:0]  vec_in   [mvt_pkg::LANES],
  input  logic signed [DATA_WIDTH-1:0]  row_coef [mvt_pkg::LANES],
  input  logic signed [DATA_WIDTH-1:0]  col_coef [mvt_pkg::LANES],
  input  logic signed [2*DATA_WIDTH+1:0] psum_in [mvt_pkg::LANES],
  output mvt_pkg::stage_ctrl_t          ctrl_out,
  input  logic                          out_free,
  output logic signed [DATA_WIDTH-1:0]  vec_out  [mvt_pkg::LANES],
  output logic signed [2*DATA_WIDTH+1:0] psum_out [mvt_pkg::LANES]
);

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int SUM_W  = 2 * DATA_WIDTH + 2;

  logic                    valid_a, valid_b;
  logic                    col_a, col_b;
  logic                    free_a, free_b;
  logic signed [DATA_WIDTH-1:0] coef_sel [mvt_pkg::LANES];
  logic signed [DATA_WIDTH-1:0] vec_a    [mvt_pkg::LANES];
  logic signed [DATA_WIDTH-1:0] vec_b    [mvt_pkg::LANES];
  logic signed [SUM_W-1:0]      psum_a   [mvt_pkg::LANES];
  logic signed [SUM_W-1:0]      psum_b   [mvt_pkg::LANES];
  logic signed [PROD_W-1:0]     prod_a   [mvt_pkg::LANES];

  // A stage loads when it is empty or its contents move on
  assign free_b  = !valid_b || out_free;
  assign free_a  = !valid_a || free_b;
  assign in_free = free_a;

  // Column vector takes column LANE of the matrix, row vector takes row LANE
  always_comb begin
    for (int i = 0; i < mvt_pkg::LANES; i++)
      coef_sel[i] = ctrl_in.is_column ? col_coef[i] : row_coef[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else begin
      if (free_a) valid_a <= ctrl_in.valid;
      if (free_b) valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (free_a && ctrl_in.valid) begin
      col_a <= ctrl_in.is_column;
      for (int i = 0; i < mvt_pkg::LANES; i++) begin
        vec_a[i]  <= vec_in[i];
        psum_a[i] <= psum_in[i];
        prod_a[i] <= vec_in[LANE] * coef_sel[i];
      end
    end
    if (free_b && valid_a) begin
      col_b <= col_a;
      for (int i = 0; i < mvt_pkg::LANES; i++) begin
        vec_b[i]  <= vec_a[i];
        psum_b[i] <= psum_a[i] + {{(SUM_W-PROD_W){prod_a[i][PROD_W-1]}}, prod_a[i]};
      end
    end
  end

  assign ctrl_out = '{valid: valid_b, is_column: col_b};

  always_comb begin
    for (int i = 0; i < mvt_pkg::LANES; i++) begin
      vec_out[i]  = vec_b[i];
      psum_out[i] = psum_b[i];
    end
  end

endmodule

>>> rtl/core/mvt_sat.sv
// Output stage: drops the fraction bits, clamps to the data range and holds the result.
module mvt_sat #(
  parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mvt_pkg::stage_ctrl_t                ctrl_in,
  output logic                                in_free,
  input  logic signed [2*DATA_WIDTH+1:0]      psum_in [mvt_pkg::LANES],
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mvt_pkg::PORT_WIDTH-1:0] result [mvt_pkg::LANES],
  output logic                                saturated
);

  localparam int SUM_W = 2 * DATA_WIDTH + 2;
  localparam int UP_W  = SUM_W - DATA_WIDTH + 1;

  localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [SUM_W-1:0]      shifted [mvt_pkg::LANES];
  logic        [UP_W-1:0]       upper   [mvt_pkg::LANES];
  logic signed [DATA_WIDTH-1:0] clamped [mvt_pkg::LANES];
  logic        [mvt_pkg::LANES-1:0] clip;

  assign in_free = !out_valid || out_ready;

  // Floor shift, then the bits above the sign position must all match it
  always_comb begin
    for (int i = 0; i < mvt_pkg::LANES; i++) begin
      shifted[i] = psum_in[i] >>> FRAC_BITS;
      upper[i]   = shifted[i][SUM_W-1:DATA_WIDTH-1];
      clip[i]    = 1'b0;
      clamped[i] = shifted[i][DATA_WIDTH-1:0];
      if (!upper[i][UP_W-1] && (|upper[i])) begin
        clip[i]    = 1'b1;
        clamped[i] = MAX_VAL;
      end else if (upper[i][UP_W-1] && !(&upper[i])) begin
        clip[i]    = 1'b1;
        clamped[i] = MIN_VAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_free) begin
      out_valid <= ctrl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && ctrl_in.valid) begin
      for (int i = 0; i < mvt_pkg::LANES; i++)
        result[i] <= mvt_pkg::PORT_WIDTH'(clamped[i]);
      saturated <= |clip;
    end
  end

endmodule

>>> rtl/core/matrix_vector_transform_core.sv
// Pipeline: four cells of two registered stages each, then one clamp register.
// One vector per cycle unless stalled; each cell runs four multipliers into a registered add.
// Stall: a full pipeline holds in_ready low only while the output register waits on out_ready.
// Reset: synchronous, clears every stage valid bit and loads the identity matrix.
// Matrix registers change only at reset or by cfg_write; indexes past the last are ignored.
module matrix_vector_transform_core #(
  parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [mvt_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [mvt_pkg::REG_WIDTH-1:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [mvt_pkg::PORT_WIDTH-1:0] elem0,
  input  logic signed [mvt_pkg::PORT_WIDTH-1:0] elem1,
  input  logic signed [mvt_pkg::PORT_WIDTH-1:0] elem2,
  input  logic signed [mvt_pkg::PORT_WIDTH-1:0] elem3,
  input  logic                                  is_column,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mvt_pkg::PORT_WIDTH-1:0] out0,
  output logic signed [mvt_pkg::PORT_WIDTH-1:0] out1,
  output logic signed [mvt_pkg::PORT_WIDTH-1:0] out2,
  output logic signed [mvt_pkg::PORT_WIDTH-1:0] out3,
  output logic                                  saturated
);

  localparam int SUM_W = 2 * DATA_WIDTH + 2;
  localparam int LN    = mvt_pkg::LANES;
  localparam int NC    = mvt_pkg::CELLS;

  logic [mvt_pkg::REG_WIDTH-1:0] cfg_reg [mvt_pkg::NUM_REGS];
  logic signed [DATA_WIDTH-1:0]  coef     [LN][LN];
  logic signed [DATA_WIDTH-1:0]  row_line [NC][LN];
  logic signed [DATA_WIDTH-1:0]  col_line [NC][LN];

  mvt_pkg::stage_ctrl_t          ctrl_chain [NC+1];
  logic                          free_chain [NC+1];
  logic signed [DATA_WIDTH-1:0]  vec_chain  [NC+1][LN];
  logic signed [SUM_W-1:0]       psum_chain [NC+1][LN];
  logic signed [mvt_pkg::PORT_WIDTH-1:0] result [LN];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < mvt_pkg::NUM_REGS; r++)
        cfg_reg[r] <= mvt_pkg::reset_value(r, FRAC_BITS);
    end else if (cfg_write && (cfg_index < mvt_pkg::CFG_INDEX_W'(mvt_pkg::NUM_REGS))) begin
      cfg_reg[cfg_index[mvt_pkg::REG_SEL_W-1:0]] <= cfg_data;
    end
  end

  // Coefficient (r,c) is the low DATA_WIDTH bits of its 32-bit half
  always_comb begin
    for (int r = 0; r < LN; r++)
      for (int c = 0; c < LN; c++)
        coef[r][c] = cfg_reg[2*r + c/2][mvt_pkg::HALF_WIDTH*(c%2) +: DATA_WIDTH];
    for (int k = 0; k < NC; k++)
      for (int i = 0; i < LN; i++) begin
        row_line[k][i] = coef[k][i];
        col_line[k][i] = coef[i][k];
      end
  end

  assign ctrl_chain[0] = '{valid: in_valid, is_column: is_column};
  assign in_ready      = free_chain[0];

  always_comb begin
    vec_chain[0][0] = elem0[DATA_WIDTH-1:0];
    vec_chain[0][1] = elem1[DATA_WIDTH-1:0];
    vec_chain[0][2] = elem2[DATA_WIDTH-1:0];
    vec_chain[0][3] = elem3[DATA_WIDTH-1:0];
    for (int i = 0; i < LN; i++)
      psum_chain[0][i] = '0;
  end

  for (genvar k = 0; k < NC; k++) begin : g_cell
    mvt_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .LANE       (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl_in  (ctrl_chain[k]),
      .in_free  (free_chain[k]),
      .vec_in   (vec_chain[k]),
      .row_coef (row_line[k]),
      .col_coef (col_line[k]),
      .psum_in  (psum_chain[k]),
      .ctrl_out (ctrl_chain[k+1]),
      .out_free (free_chain[k+1]),
      .vec_out  (vec_chain[k+1]),
      .psum_out (psum_chain[k+1])
    );
  end

  mvt_sat #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_sat (
    .clk       (clk),
    .rst       (rst),
    .ctrl_in   (ctrl_chain[NC]),
    .in_free   (free_chain[NC]),
    .psum_in   (psum_chain[NC]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .saturated (saturated)
  );

  assign out0 = result[0];
  assign out1 = result[1];
  assign out2 = result[2];
  assign out3 = result[3];

endmodule

>>> rtl/core/mvt_checker.sv
// Port-level checks for the matrix-vector transform core, bound to the top level.
module mvt_checker #(
  parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [mvt_pkg::PORT_WIDTH-1:0] out0,
  input logic signed [mvt_pkg::PORT_WIDTH-1:0] out1,
  input logic signed [mvt_pkg::PORT_WIDTH-1:0] out2,
  input logic signed [mvt_pkg::PORT_WIDTH-1:0] out3,
  input logic                                  saturated
);

  localparam logic signed [mvt_pkg::PORT_WIDTH-1:0] MAX_OUT =
    mvt_pkg::PORT_WIDTH'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [mvt_pkg::PORT_WIDTH-1:0] MIN_OUT = -MAX_OUT - 1;

  // Lanes 0 and 3 and the clamp flag hold while the consumer stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out0) && $stable(out3)
      && $stable(saturated))
    else $error("result changed while stalled");

  // Input stalls only when a result is waiting and is not taken
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

  // Clamp flag needs at least one lane at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (out0 == MAX_OUT || out0 == MIN_OUT
      || out1 == MAX_OUT || out1 == MIN_OUT || out2 == MAX_OUT || out2 == MIN_OUT
      || out3 == MAX_OUT || out3 == MIN_OUT))
    else $error("saturated flag without a clamped lane");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind matrix_vector_transform_core mvt_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_mvt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out0      (out0),
  .out1      (out1),
  .out2      (out2),
  .out3      (out3),
  .saturated (saturated)
);

>>> tb/sv/tb_top.sv
// Self-checking bench for the 4x4 matrix-vector transform core.
`timescale 1ns / 100ps

module tb_top;

  localparam int FRAC_BITS      = mvt_pkg::FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES  = 12;    // pipeline latency plus margin
  localparam int HOLD_CYCLES    = 100;
  localparam int HOLD_PHASE     = 2;
  localparam int HOLD_ITEMS     = 48;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 175;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [mvt_pkg::CFG_INDEX_W-1:0] REG_ROW0_COLS01 = 4'd0;
  localparam logic [mvt_pkg::CFG_INDEX_W-1:0] REG_ROW0_COLS23 = 4'd1;
  localparam logic [mvt_pkg::CFG_INDEX_W-1:0] REG_ROW1_COLS01 = 4'd2;
  localparam logic [mvt_pkg::CFG_INDEX_W-1:0] REG_ROW1_COLS23 = 4'd3;
  localparam logic [mvt_pkg::CFG_INDEX_W-1:0] REG_ROW2_COLS01 = 4'd4;
  localparam logic [mvt_pkg::CFG_INDEX_W-1:0] REG_ROW2_COLS23 = 4'd5;
  localparam logic [mvt_pkg::CFG_INDEX_W-1:0] REG_ROW3_COLS01 = 4'd6;
  localparam logic [mvt_pkg::CFG_INDEX_W-1:0] REG_ROW3_COLS23 = 4'd7;
  localparam logic [mvt_pkg::CFG_INDEX_W-1:0] UNMAPPED_FIRST  = 4'd8;
  localparam logic [mvt_pkg::CFG_INDEX_W-1:0] UNMAPPED_LAST   = 4'd15;

  localparam logic signed [65:0] SUM_MAX  = 66'sd2147483647;
  localparam logic signed [65:0] SUM_MIN  = -66'sd2147483648;
  localparam logic [31:0]        LANE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0]        LANE_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [3:0][31:0] lane;
    logic             sat;
  } transform_result_t;

  typedef enum int {STYLE_SMALL, STYLE_MIXED, STYLE_WIDE} word_style_t;

  class vertex_scoreboard;
    logic [63:0]       matrix_regs [mvt_pkg::NUM_REGS];
    transform_result_t pending_results [$];
    int unsigned       mismatches;
    int unsigned       results_checked;
    int unsigned       saturated_count;
    int unsigned       column_count;
    int unsigned       row_count;

    function new();
      int i;
      for (i = 0; i < mvt_pkg::NUM_REGS; i++) matrix_regs[i] = '0;
      // identity, 1.0 on the diagonal
      matrix_regs[REG_ROW0_COLS01] = 64'h0000_0000_0001_0000;
      matrix_regs[REG_ROW1_COLS01] = 64'h0001_0000_0000_0000;
      matrix_regs[REG_ROW2_COLS23] = 64'h0000_0000_0001_0000;
      matrix_regs[REG_ROW3_COLS23] = 64'h0001_0000_0000_0000;
    endfunction

    function void write_reg(int unsigned idx, logic [63:0] value);
      if (idx < mvt_pkg::NUM_REGS) matrix_regs[idx] = value;
    endfunction

    function logic signed [31:0] coefficient(int unsigned row, int unsigned col);
      logic [63:0] word;
      word = matrix_regs[row * 2 + col / 2];
      return (col % 2) ? word[63:32] : word[31:0];
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Predict the transformed vector for one accepted transfer
    function void note_vector(logic signed [31:0] e0, logic signed [31:0] e1,
                              logic signed [31:0] e2, logic signed [31:0] e3,
                              logic col);
      logic signed [31:0] vec [4];
      logic signed [31:0] coef;
      logic signed [63:0] prod;
      logic signed [65:0] acc;
      logic signed [65:0] scaled;
      transform_result_t  want;
      int                 i;
      int                 k;
      vec[0] = e0;
      vec[1] = e1;
      vec[2] = e2;
      vec[3] = e3;
      want.sat = 1'b0;
      for (i = 0; i < 4; i++) begin
        acc = '0;
        for (k = 0; k < 4; k++) begin
          coef = col ? coefficient(i, k) : coefficient(k, i);
          prod = coef * vec[k];
          acc  = acc + prod;
        end
        scaled = acc >>> FRAC_BITS;
        if (scaled > SUM_MAX) begin
          want.lane[i] = LANE_MAX;
          want.sat     = 1'b1;
        end else if (scaled < SUM_MIN) begin
          want.lane[i] = LANE_MIN;
          want.sat     = 1'b1;
        end else begin
          want.lane[i] = scaled[31:0];
        end
      end
      if (col) column_count++;
      else row_count++;
      pending_results = {pending_results, want};
    endfunction

    function void check_result(logic [31:0] o0, logic [31:0] o1, logic [31:0] o2,
                               logic [31:0] o3, logic sat_flag);
      transform_result_t want;
      transform_result_t got;
      logic              bad;
      int                i;
      got.lane[0] = o0;
      got.lane[1] = o1;
      got.lane[2] = o2;
      got.lane[3] = o3;
      got.sat     = sat_flag;
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result %h %h %h %h sat %b with no vector outstanding",
                   $realtime, o0, o1, o2, o3, sat_flag);
        return;
      end
      want = pending_results.pop_front();
      if (want.sat) saturated_count++;
      bad = (got.sat !== want.sat);
      for (i = 0; i < 4; i++) bad = bad | (got.lane[i] !== want.lane[i]);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result %0d: expected %h %h %h %h sat %b, got %h %h %h %h sat %b",
                   $realtime, results_checked, want.lane[0], want.lane[1], want.lane[2],
                   want.lane[3], want.sat, o0, o1, o2, o3, sat_flag);
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [mvt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mvt_pkg::REG_WIDTH-1:0]   cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [31:0]                     elem0 = '0;
  logic [31:0]                     elem1 = '0;
  logic [31:0]                     elem2 = '0;
  logic [31:0]                     elem3 = '0;
  logic                            is_column = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [31:0]                     out0;
  logic [31:0]                     out1;
  logic [31:0]                     out2;
  logic [31:0]                     out3;
  logic                            saturated;

  vertex_scoreboard sb = new();
  bit               quiet = 1'b0;
  bit               burst_mode = 1'b0;
  bit               hold_req = 1'b0;
  int unsigned      stalled_cycles = 0;
  int unsigned      matrix_settings = 1;

  matrix_vector_transform_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .elem0     (elem0),
    .elem1     (elem1),
    .elem2     (elem2),
    .elem3     (elem3),
    .is_column (is_column),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out0      (out0),
    .out1      (out1),
    .out2      (out2),
    .out3      (out3),
    .saturated (saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5: return 32'h0001_0000;
      6: return 32'hFFFF_0000;
      default: return 32'h0000_8000;
    endcase
  endfunction

  // Small words stay within +/-8.0 so sums rarely clamp; wide words mostly do
  function automatic logic [31:0] pick_word(word_style_t style);
    int unsigned roll;
    logic [31:0] small_word;
    roll       = $urandom_range(0, 9);
    small_word = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    case (style)
      STYLE_SMALL: return (roll < 9) ? small_word : edge_word();
      STYLE_MIXED: return (roll < 5) ? small_word : (roll < 8) ? $urandom : edge_word();
      default:     return (roll < 6) ? $urandom : edge_word();
    endcase
  endfunction

  task automatic send_vector(input logic [31:0] e0, input logic [31:0] e1,
                             input logic [31:0] e2, input logic [31:0] e3,
                             input logic col);
    in_valid  <= 1'b1;
    elem0     <= e0;
    elem1     <= e1;
    elem2     <= e2;
    elem3     <= e3;
    is_column <= col;
    do @(posedge clk); while (!in_ready);
    if (!quiet && !burst_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [mvt_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mvt_pkg::REG_WIDTH-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic end_writes();
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic fill_matrix(input logic [63:0] value);
    int unsigned idx;
    for (idx = 0; idx < mvt_pkg::NUM_REGS; idx++)
      write_reg(mvt_pkg::CFG_INDEX_W'(idx), value);
    end_writes();
    matrix_settings++;
  endtask

  // Stop offering, wait for every outstanding result, then let the pipe settle
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out0, out1, out2, out3, saturated);
      if (in_valid && in_ready) sb.note_vector(elem0, elem1, elem2, elem3, is_column);
      if ((out_valid && out_ready) || (in_valid && in_ready)) stalled_cycles = 0;
      else stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
                 $realtime, stalled_cycles, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : result_sink
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_idx;
    int unsigned item_idx;
    int unsigned idx;
    word_style_t mat_style;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // identity matrix from reset: extremes pass through unchanged
    send_vector(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 1'b1);
    send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0);
    send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_0000, 1'b0);

    // writes past the last register must leave the matrix alone
    quiesce();
    write_reg(UNMAPPED_FIRST, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(UNMAPPED_LAST, 64'h5555_5555_AAAA_AAAA);
    end_writes();
    send_vector(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 1'b1);

    // largest positive coefficients: clamp both ways, and exact cancellation
    quiesce();
    fill_matrix({2{LANE_MAX}});
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_vector(32'h7FFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0001, 1'b1);
    send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);

    // most negative coefficients: the full sum needs more than 64 bits
    quiesce();
    fill_matrix({2{LANE_MIN}});
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);

    // sparse matrix: clamp by one, exact limits, flooring of negative sums
    quiesce();
    write_reg(REG_ROW0_COLS01, 64'h0000_0001_0001_0000);
    write_reg(REG_ROW0_COLS23, 64'h0000_0000_0000_0000);
    write_reg(REG_ROW1_COLS01, 64'h0002_0000_FFFF_0000);
    write_reg(REG_ROW1_COLS23, 64'h0000_0000_0000_0000);
    write_reg(REG_ROW2_COLS01, 64'h0000_0000_0000_0000);
    write_reg(REG_ROW2_COLS23, 64'hFFFF_FFFF_0000_8000);
    write_reg(REG_ROW3_COLS01, 64'h0000_0000_0003_0000);
    write_reg(REG_ROW3_COLS23, 64'hFFFD_0000_0000_0000);
    end_writes();
    matrix_settings++;
    send_vector(32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0003, 32'h0000_0005, 1'b1);
    send_vector(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_vector(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_vector(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1);
    send_vector(32'h0001_8000, 32'hFFFE_8000, 32'h0005_0000, 32'h0000_4000, 1'b0);

    for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
      quiesce();
      quiet     = (phase_idx >= RANDOM_PHASES - 2);
      mat_style = word_style_t'(phase_idx % 3);
      for (idx = 0; idx < mvt_pkg::NUM_REGS; idx++)
        if (phase_idx == 0 || $urandom_range(0, 3) != 0)
          write_reg(mvt_pkg::CFG_INDEX_W'(idx), {pick_word(mat_style), pick_word(mat_style)});
      if ($urandom_range(0, 2) == 0)
        write_reg(mvt_pkg::CFG_INDEX_W'($urandom_range(UNMAPPED_FIRST, UNMAPPED_LAST)),
                  {$urandom, $urandom});
      end_writes();
      matrix_settings++;
      // hold the output side while offering back to back to fill the pipe
      if (phase_idx == HOLD_PHASE) begin
        hold_req   = 1'b1;
        burst_mode = 1'b1;
      end
      for (item_idx = 0; item_idx < PHASE_ITEMS; item_idx++) begin
        if (item_idx == HOLD_ITEMS) burst_mode = 1'b0;
        send_vector(pick_word(word_style_t'($urandom_range(0, 2))),
                    pick_word(word_style_t'($urandom_range(0, 2))),
                    pick_word(word_style_t'($urandom_range(0, 2))),
                    pick_word(word_style_t'($urandom_range(0, 2))),
                    1'($urandom_range(0, 1)));
      end
    end

    quiesce();
    $display("covered %0d vectors (%0d column, %0d row) over %0d matrix settings",
             sb.column_count + sb.row_count, sb.column_count, sb.row_count,
             matrix_settings);
    $display("checked %0d results, %0d clamped, %0d mismatches",
             sb.results_checked, sb.saturated_count, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
